[rtl/ndf_pkg.sv]
// Shared types, sizes and helper functions for the four-neighbour despeckle filter.
// No dependencies; every other rtl file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ndf_pkg;

    localparam int MAX_ROWS   = 32;
    localparam int MAX_COLS   = 32;
    localparam int PIXEL_BITS = 4;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int SIZE_W = 6;
    localparam int SUM_W  = PIXEL_BITS + 2;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;

    localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(20);
    localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(30);

    typedef logic [PIXEL_BITS-1:0] level_t;
    typedef logic [SIZE_W-1:0]     size_t;

    // Which in-image neighbours the pixel under correction has
    typedef struct packed {
        logic has_left;
        logic has_up;
        logic has_right;
        logic has_below;
    } ndf_edges_t;

    // Saturate a size register to 2..hi
    function automatic size_t clamp_size(input size_t v, input size_t hi);
        size_t r;
        if (v < SIZE_W'(2))
            r = SIZE_W'(2);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    // Floor of a sum of three levels over three: reciprocal multiply, exact below 64
    function automatic level_t div_by_3(input logic [SUM_W-1:0] s);
        logic [SUM_W+6:0] prod;
        prod = (SUM_W+7)'(s) * (SUM_W+7)'(43);
        return PIXEL_BITS'(prod >> 7);
    endfunction

endpackage

`default_nettype wire

[rtl/ndf_cell.sv]
// One storage cell of a pixel delay chain: loads the inserted level or its neighbour's.
// Depends on ndf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ndf_cell (
    input  wire              clk,
    input  wire              shift_en,
    input  wire              load_sel,
    input  ndf_pkg::level_t  ins_level,
    input  ndf_pkg::level_t  nbr_level,
    output ndf_pkg::level_t  level
);
    import ndf_pkg::*;

    level_t level_reg;
    level_t level_next;

    always_comb
    begin
        level_next = load_sel ? ins_level : nbr_level;
    end

    // Payload only: no reset
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

[rtl/ndf_decide.sv]
// Correction unit: replaces a pixel by the floor mean of its neighbours when all exceed it by at least two.
// Depends on ndf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ndf_decide (
    input  ndf_pkg::level_t     center,
    input  ndf_pkg::level_t     left,
    input  ndf_pkg::level_t     up,
    input  ndf_pkg::level_t     right,
    input  ndf_pkg::level_t     below,
    input  ndf_pkg::ndf_edges_t edges,
    output ndf_pkg::level_t     result
);
    import ndf_pkg::*;

    logic [PIXEL_BITS:0] thresh;
    logic                all_above;
    logic [SUM_W-1:0]    sum;
    logic [2:0]          count;
    level_t              mean;

    always_comb
    begin
        thresh    = {1'b0, center} + (PIXEL_BITS+1)'(1);
        all_above = 1'b1;
        sum       = '0;
        count     = '0;
        if (edges.has_left)
        begin
            if (!({1'b0, left} > thresh)) all_above = 1'b0;
            sum   = sum + SUM_W'(left);
            count = count + 3'd1;
        end
        if (edges.has_up)
        begin
            if (!({1'b0, up} > thresh)) all_above = 1'b0;
            sum   = sum + SUM_W'(up);
            count = count + 3'd1;
        end
        if (edges.has_right)
        begin
            if (!({1'b0, right} > thresh)) all_above = 1'b0;
            sum   = sum + SUM_W'(right);
            count = count + 3'd1;
        end
        if (edges.has_below)
        begin
            if (!({1'b0, below} > thresh)) all_above = 1'b0;
            sum   = sum + SUM_W'(below);
            count = count + 3'd1;
        end

        case (count)
            3'd2:    mean = PIXEL_BITS'(sum >> 1);
            3'd3:    mean = div_by_3(sum);
            3'd4:    mean = PIXEL_BITS'(sum >> 2);
            default: mean = center;
        endcase

        result = all_above ? mean : center;
    end

endmodule

`default_nettype wire

[rtl/neighbor_despeckle_filter_top.sv]
// Top level of the four-neighbour despeckle filter: position control, two delay chains,
// correction unit and output register. Depends on ndf_pkg, ndf_cell and ndf_decide.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  pixel_in
//   result    out        out_valid / out_stall pixel_out, last_pixel
//   config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One input item is taken per cycle while in_stall is low; the item for row r > 0
// yields the corrected pixel one row above it, registered as the item is taken. The final
// item of an image is followed by ncols flush slots, one per last-row result, during which
// in_stall is held high; the flush length is set by the configured column count.
// Reset clears position, flush state and output valid, and sets the size registers to 20 x 30.
// A stalled result holds the output register; in_stall then rises in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module neighbor_despeckle_filter_top (
    input  wire                          clk,
    input  wire                          rst_n,
    // pixel items in
    input  wire                          in_valid,
    output logic                         in_stall,
    input  ndf_pkg::level_t              pixel_in,
    // corrected items out
    output logic                         out_valid,
    input  wire                          out_stall,
    output ndf_pkg::level_t              pixel_out,
    output logic                         last_pixel,
    // register writes
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [1:0]                   cfg_index,
    input  ndf_pkg::size_t               cfg_data
);
    import ndf_pkg::*;

    // ---------------------------------------------------------------
    // Size registers and saturated sizes
    // ---------------------------------------------------------------
    size_t rows_reg;
    size_t cols_reg;
    size_t nrows;
    size_t ncols;
    logic [ROW_W-1:0] nrows_m1;
    logic [COL_W-1:0] ncols_m1;

    always_comb
    begin
        nrows    = clamp_size(rows_reg, SIZE_W'(MAX_ROWS));
        ncols    = clamp_size(cols_reg, SIZE_W'(MAX_COLS));
        nrows_m1 = ROW_W'(nrows - SIZE_W'(1));
        ncols_m1 = COL_W'(ncols - SIZE_W'(1));
    end

    // ---------------------------------------------------------------
    // Position and flush control
    // ---------------------------------------------------------------
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             flush_reg;
    logic             flush_next;

    logic out_valid_reg;
    logic out_valid_next;
    level_t pixel_out_reg;
    logic   last_reg;

    logic out_free;
    logic in_take;
    logic step_en;
    logic emit;
    logic col_last;
    logic row_last;
    logic cfg_take;
    logic cfg_known;

    // The output register is free when empty or being taken this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = flush_reg || !out_free;
    assign in_take   = in_valid && !in_stall;
    // A step is one slot of the chains: a real input or a flush slot
    assign step_en   = in_take || (flush_reg && out_free);
    assign emit      = flush_reg || (row_reg != '0);
    assign col_last  = (col_reg == ncols_m1);
    assign row_last  = (row_reg == nrows_m1);

    assign cfg_ready = !flush_reg && !out_valid_reg;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == REG_ROWS) || (cfg_index == REG_COLS);

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        flush_next = flush_reg;
        if (cfg_take && cfg_known)
        begin
            // restart the image, drop pixels already taken
            row_next   = '0;
            col_next   = '0;
            flush_next = 1'b0;
        end
        else if (step_en)
        begin
            if (flush_reg)
            begin
                if (col_last)
                begin
                    row_next   = '0;
                    col_next   = '0;
                    flush_next = 1'b0;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            else if (col_last && row_last)
            begin
                // final pixel: hold the row, sweep it out in flush slots
                col_next   = '0;
                flush_next = 1'b1;
            end
            else if (col_last)
            begin
                row_next = row_reg + ROW_W'(1);
                col_next = '0;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= ROWS_RESET;
            cols_reg  <= COLS_RESET;
            row_reg   <= '0;
            col_reg   <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            if (cfg_take && (cfg_index == REG_ROWS)) rows_reg <= cfg_data;
            if (cfg_take && (cfg_index == REG_COLS)) cols_reg <= cfg_data;
            row_reg   <= row_next;
            col_reg   <= col_next;
            flush_reg <= flush_next;
        end
    end

    // ---------------------------------------------------------------
    // Delay chains. Each chain inserts at cell ncols-1 and advances
    // toward cell 0, so cell 0 shows the item ncols slots old.
    //   orig chain: original levels (cell 0 = centre, cell 1 = right)
    //   corr chain: corrected levels (cell 0 = upper neighbour)
    // ---------------------------------------------------------------
    level_t orig_lvl [MAX_COLS];
    level_t corr_lvl [MAX_COLS];
    level_t orig_ins;
    level_t corr_ins;
    level_t left_reg;

    assign orig_ins = flush_reg ? '0 : pixel_in;

    for (genvar i = 0; i < MAX_COLS; i++)
    begin : g_cell
        localparam logic [COL_W-1:0] IDX = COL_W'(i);
        level_t orig_nbr;
        level_t corr_nbr;
        logic   sel;

        assign sel = (IDX == ncols_m1);

        if (i == MAX_COLS - 1)
        begin : g_top
            assign orig_nbr = '0;
            assign corr_nbr = '0;
        end
        else
        begin : g_mid
            assign orig_nbr = orig_lvl[i+1];
            assign corr_nbr = corr_lvl[i+1];
        end

        ndf_cell u_orig (
            .clk       (clk),
            .shift_en  (step_en),
            .load_sel  (sel),
            .ins_level (orig_ins),
            .nbr_level (orig_nbr),
            .level     (orig_lvl[i])
        );

        ndf_cell u_corr (
            .clk       (clk),
            .shift_en  (step_en),
            .load_sel  (sel),
            .ins_level (corr_ins),
            .nbr_level (corr_nbr),
            .level     (corr_lvl[i])
        );
    end

    // ---------------------------------------------------------------
    // Correction of the pixel one row above the current slot
    // ---------------------------------------------------------------
    ndf_edges_t edges;

    always_comb
    begin
        edges.has_left  = (col_reg != '0);
        // in flush the row under correction is the last one, never the first
        edges.has_up    = flush_reg || (row_reg > ROW_W'(1));
        edges.has_right = (col_reg < ncols_m1);
        edges.has_below = !flush_reg;
    end

    ndf_decide u_decide (
        .center (orig_lvl[0]),
        .left   (left_reg),
        .up     (corr_lvl[0]),
        .right  (orig_lvl[1]),
        .below  (pixel_in),
        .edges  (edges),
        .result (corr_ins)
    );

    // Left neighbour is the level corrected in the previous slot
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            left_reg <= corr_ins;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_en)
            out_valid_next = emit;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            pixel_out_reg <= corr_ins;
            last_reg      <= flush_reg && col_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign last_pixel = last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= nrows_m1) && (col_reg <= ncols_m1))
        else $error("position outside the configured image");

    a_flush_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> (row_last && in_stall && !cfg_ready))
        else $error("flush away from the last row or input not held");

    a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && flush_reg && col_last) |=> (out_valid && last_pixel && !flush_reg))
        else $error("end of flush without a marked final item");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_take && cfg_known) |=> ((row_reg == '0) && (col_reg == '0) && !flush_reg))
        else $error("register write did not restart the image");

    a_no_step_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !step_en)
        else $error("step taken while a result is held");

endmodule

`default_nettype wire

[tb/ndf_scoreboard.sv]
// Scoreboard for the four-neighbour despeckle filter: follows the item, result and register
// channels, predicts every corrected level and compares it with what the block emits.
// Depends on ndf_pkg for level and size types, register indexes and reset sizes.
`timescale 1ns / 1ps

module ndf_scoreboard
    import ndf_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    input  wire         in_stall,
    input  level_t      pixel_in,
    input  wire         out_valid,
    input  wire         out_stall,
    input  level_t      pixel_out,
    input  wire         last_pixel,
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  size_t       cfg_data,
    output int          mismatch_count,
    output int          pending_results
);

    typedef struct packed {
        level_t pixel;
        logic   is_last;
    } despeckled_t;

    level_t        row_pair [0:2*MAX_COLS-1];
    size_t         rows_reg;
    size_t         cols_reg;
    int unsigned   row_at;
    int unsigned   col_at;
    despeckled_t   expected_q [$];

    function automatic int unsigned pair_slot(input int unsigned r, input int unsigned c);
        return (r % 2) * MAX_COLS + (c % MAX_COLS);
    endfunction

    // Saturate a size register to the range the block supports
    function automatic int unsigned usable_size(input size_t v, input int unsigned hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Correct one pixel in place from its in-image neighbours
    function automatic level_t despeckle_at(input int unsigned r, input int unsigned c,
                                            input int unsigned below,
                                            input int unsigned nr, input int unsigned nc);
        int unsigned centre;
        int unsigned v;
        int unsigned total;
        int unsigned count;
        bit          all_higher;
        centre     = row_pair[pair_slot(r, c)];
        total      = 0;
        count      = 0;
        all_higher = 1'b1;
        if (c > 0)
        begin
            v = row_pair[pair_slot(r, c - 1)];
            if (v <= centre + 1) all_higher = 1'b0;
            total += v;
            count++;
        end
        if (r > 0)
        begin
            v = row_pair[pair_slot(r - 1, c)];
            if (v <= centre + 1) all_higher = 1'b0;
            total += v;
            count++;
        end
        if (c + 1 < nc)
        begin
            v = row_pair[pair_slot(r, c + 1)];
            if (v <= centre + 1) all_higher = 1'b0;
            total += v;
            count++;
        end
        if (r + 1 < nr)
        begin
            v = below;
            if (v <= centre + 1) all_higher = 1'b0;
            total += v;
            count++;
        end
        if (all_higher && count > 0)
            centre = (total / count) % (1 << PIXEL_BITS);
        row_pair[pair_slot(r, c)] = level_t'(centre);
        return level_t'(centre);
    endfunction

    task automatic take_pixel(input level_t pix);
        int unsigned nr;
        int unsigned nc;
        int unsigned r;
        int unsigned c;
        despeckled_t res;
        nr = usable_size(rows_reg, MAX_ROWS);
        nc = usable_size(cols_reg, MAX_COLS);
        r  = row_at;
        c  = col_at;
        if (r >= nr || c >= nc)
        begin
            r = 0;
            c = 0;
        end
        // the pixel one row up is now complete
        if (r > 0)
        begin
            res.pixel   = despeckle_at(r - 1, c, pix, nr, nc);
            res.is_last = 1'b0;
            expected_q.push_back(res);
        end
        row_pair[pair_slot(r, c)] = pix;
        if (r + 1 == nr && c + 1 == nc)
        begin
            // final pixel: flush the bottom row
            for (int x = 0; x < nc; x++)
            begin
                res.pixel   = despeckle_at(r, x, 0, nr, nc);
                res.is_last = (x + 1 == nc);
                expected_q.push_back(res);
            end
            row_at = 0;
            col_at = 0;
        end
        else if (c + 1 == nc)
        begin
            row_at = r + 1;
            col_at = 0;
        end
        else
        begin
            row_at = r;
            col_at = c + 1;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        despeckled_t want;
        if (!rst_n)
        begin
            rows_reg        = ROWS_RESET;
            cols_reg        = COLS_RESET;
            row_at          = 0;
            col_at          = 0;
            mismatch_count  = 0;
            pending_results = 0;
            expected_q.delete();
            for (int i = 0; i < 2 * MAX_COLS; i++)
                row_pair[i] = '0;
        end
        else
        begin
            // a write to a known register restarts the image; unknown indexes are ignored
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ROWS)
                begin
                    rows_reg = cfg_data;
                    row_at   = 0;
                    col_at   = 0;
                end
                else if (cfg_index == REG_COLS)
                begin
                    cols_reg = cfg_data;
                    row_at   = 0;
                    col_at   = 0;
                end
            end
            if (in_valid && !in_stall)
                take_pixel(pixel_in);
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d/%0d with nothing expected",
                                              pixel_out, last_pixel));
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (pixel_out !== want.pixel)
                        report_mismatch($sformatf("pixel_out %0d, expected %0d",
                                                  pixel_out, want.pixel));
                    if (last_pixel !== want.is_last)
                        report_mismatch($sformatf("last_pixel %0b, expected %0b",
                                                  last_pixel, want.is_last));
                end
            end
            pending_results = expected_q.size();
        end
    end

endmodule

[tb/tb_neighbor_despeckle_filter_top.sv]
// Stimulus and verdict for the four-neighbour despeckle filter.
// Depends on ndf_pkg, the filter RTL and the ndf_scoreboard module beside it.
`timescale 1ns / 1ps

module tb_neighbor_despeckle_filter_top;

    import ndf_pkg::*;

    // Index outside the register map; a write to it must change nothing
    localparam logic [1:0] REG_SPARE = 2'd3;

    // Cycles to let the block settle once nothing is expected (pipeline is one deep)
    localparam int SETTLE_CYCLES = 4;
    // Roughly 250 items and as many results under heavy stalling fit well inside this
    localparam int CYCLE_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    level_t      pixel_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    level_t      pixel_out;
    logic        last_pixel;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_ROWS;
    size_t       cfg_data = '0;

    int          mismatch_count;
    int          pending_results;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          items_sent = 0;
    int          cycle_count = 0;

    always #5 clk = ~clk;

    neighbor_despeckle_filter_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .last_pixel (last_pixel),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    ndf_scoreboard i_scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel_in        (pixel_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pixel_out       (pixel_out),
        .last_pixel      (last_pixel),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Receiver back-pressure: redraw the stall at every falling edge
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog: give up well beyond the slowest correct run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_neighbor_despeckle_filter_top failed");
            $finish;
        end
    end

    // Mostly a bright background with dark speckles, so that corrections do happen;
    // otherwise any level at all.
    function automatic level_t pick_level(input bit speckled);
        if (!speckled)
            return level_t'($urandom_range(15));
        if ($urandom_range(4) == 0)
            return level_t'($urandom_range(0, 8));
        return level_t'($urandom_range(10, 15));
    endfunction

    // Offer one item and hold it until it is taken. Called and left at a falling edge,
    // with in_valid still high: the caller's next step must drive in_valid again.
    task automatic feed_level(input level_t lvl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= lvl;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    // Drop valid and hold off until every predicted result has come out
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    // Register writes only ever happen with the block drained and settled
    task automatic write_size_reg(input logic [1:0] idx, input size_t value);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write both sizes, in either order; each write restarts the image
    task automatic set_size(input size_t rows_raw, input size_t cols_raw);
        if ($urandom_range(1))
        begin
            write_size_reg(REG_ROWS, rows_raw);
            write_size_reg(REG_COLS, cols_raw);
        end
        else
        begin
            write_size_reg(REG_COLS, cols_raw);
            write_size_reg(REG_ROWS, rows_raw);
        end
    endtask

    // Feed n levels packed as nibbles, first pixel in the most significant one
    task automatic feed_pattern(input logic [63:0] levels, input int n);
        for (int k = 0; k < n; k++)
            feed_level(levels[4 * (n - 1 - k) +: 4]);
    endtask

    // One image of the current size; a non-zero cut stops it early so that the next
    // register write drops the part already taken
    task automatic stream_image(input int nr, input int nc, input bit speckled, input int cut);
        int total;
        int pause_at;
        total    = (cut > 0) ? cut : nr * nc;
        pause_at = ($urandom_range(3) == 0) ? $urandom_range(total - 1) : -1;
        for (int k = 0; k < total; k++)
        begin
            if (k == pause_at)
                wait_for_results();
            feed_level(pick_level(speckled));
        end
    endtask

    // Random images, mostly small, now and then a full-width strip
    task automatic random_images(input int budget);
        int start_count;
        int nr;
        int nc;
        int groups;
        int cut;
        bit speckled;
        start_count = items_sent;
        while (items_sent - start_count < budget)
        begin
            nr = $urandom_range(2, 6);
            nc = $urandom_range(2, 9);
            if ($urandom_range(7) == 0)
            begin
                nr = 2;
                nc = MAX_COLS;
            end
            set_size(size_t'(nr), size_t'(nc));
            groups = $urandom_range(1, 2);
            for (int g = 0; g < groups; g++)
            begin
                speckled = ($urandom_range(3) != 0);
                cut = 0;
                // only the last image of a group may be cut short
                if (g == groups - 1 && $urandom_range(4) == 0)
                    cut = $urandom_range(1, nr * nc - 1);
                stream_image(nr, nc, speckled, cut);
            end
        end
    endtask

    initial
    begin
        // hold reset, then release it away from the rising edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sender idles a quarter of the time, receiver stalls most of the time
        send_idle_pct = 26;
        stall_pct     = 78;

        // reset size 20 x 30: the whole top row and one pixel more, then a restart
        stream_image(20, 30, 1'b0, 31);

        set_size(3, 3);
        // dark centre inside a flat field, with a full drain half way through
        feed_pattern(64'hCCCC0, 5);
        wait_for_results();
        feed_pattern(64'hCCCC, 4);
        // dark corners and edges; a write to an unmapped index must not restart
        feed_pattern(64'h0F24, 4);
        write_size_reg(REG_SPARE, '1);
        feed_pattern(64'hFF3F1, 5);
        // edge pixel with three brighter neighbours
        feed_pattern(64'h789499699, 9);

        // smallest image, extreme levels
        set_size(2, 2);
        feed_pattern(64'hF00F, 4);
        feed_pattern(64'h0FF0, 4);

        // now the sender idles most of the time and the receiver rarely stalls
        send_idle_pct = 78;
        stall_pct     = 26;

        // rows above range saturate to the maximum, columns below range to two
        set_size('1, '0);
        stream_image(MAX_ROWS, 2, 1'b1, 0);

        // no idling on either side
        send_idle_pct = 0;
        stall_pct     = 0;

        set_size(1, 33);
        stream_image(2, MAX_COLS, 1'b1, 0);
        set_size(0, 1);
        stream_image(2, 2, 1'b0, 0);
        random_images(10);

        // drain, then let the pipeline settle for stray results
        wait_for_results();
        repeat (SETTLE_CYCLES * 2) @(negedge clk);

        if (mismatch_count == 0 && pending_results == 0)
            $display("tb_neighbor_despeckle_filter_top passed");
        else
            $display("tb_neighbor_despeckle_filter_top failed");
        $finish;
    end

endmodule
